// ===== hdl/ise_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_pkg
// shared sizes, op and status codes, and the command types passed from the
// front queue to the stack back end
// ----------------------------------------------------------------------------
package ise_pkg;

    localparam int DEPTH       = 32;
    localparam int MAX_RESULTS = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int REM_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_DUMP = 3'd1;
    localparam logic [2:0] OP_POP  = 3'd2;
    localparam logic [2:0] OP_PEEK = 3'd3;
    localparam logic [2:0] OP_SWAP = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_POP_EMPTY  = 3'd1;
    localparam logic [2:0] ST_PEEK_EMPTY = 3'd2;
    localparam logic [2:0] ST_SWAP_SHORT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    typedef enum logic [2:0] {
        K_PUSH,
        K_DUMP,
        K_POP,
        K_PEEK,
        K_SWAP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } back_stat_t;

endpackage

`default_nettype wire

// ===== hdl/integer_stack_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_stack_engine_core
// lifo stack of signed 32-bit entries with push, pop, peek, swap and dump
// ----------------------------------------------------------------------------
// input side: drive op and value with push; the item is taken on an edge where
// push is high and full is low. a two-entry command queue sits behind it, so
// full only rises while the stack side is busy. ops 5 to 7 are taken and dropped.
// result side: while empty is low the oldest result is on data, data_valid,
// status and last; pop takes it. one output register holds it, so a stalled
// receiver simply backs up into the command queue and then into full.
// push, pop and errors are carried out one item a cycle while the receiver
// keeps popping; during a peek, swap or dump the stack side takes no new
// command until it is done. swap writes its two entries in turn (single write
// port on the stack memory); a dump makes one memory read per emitted entry.
// reset clears the entry count, the sequencer state, the command queue and the
// output valid flag; the stack memory itself is not cleared and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module integer_stack_engine_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] value,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      data,
    output logic                    data_valid,
    output logic [2:0]              status,
    output logic                    last
);

    ise_pkg::cmd_t       cmd;
    logic                cmd_valid;
    logic                cmd_take;
    ise_pkg::back_stat_t stat;

    ise_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .value     (value),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    ise_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .empty      (empty),
        .pop        (pop),
        .data       (data),
        .data_valid (data_valid),
        .status     (status),
        .last       (last),
        .stat       (stat)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(stat.count) <= ise_pkg::DEPTH)
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.count > $past(stat.count)) |-> (stat.count == $past(stat.count) + 1'b1))
        else $error("entry count grew by more than one");

    a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && data_valid) |-> (status == ise_pkg::ST_OK))
        else $error("entry result with error status");

    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !data_valid) |-> (last && data == 32'sd0))
        else $error("non-entry result not marked last or data not zero");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.idle |-> !cmd_take)
        else $error("command taken while sequencer busy");

endmodule

`default_nettype wire

// ===== hdl/ise_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_front
// accepts input items, decodes the op and queues commands for the back end;
// items with an unknown op are accepted and dropped
// ----------------------------------------------------------------------------
module ise_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] value,
    output ise_pkg::cmd_t           cmd,
    output logic                    cmd_valid,
    input  wire logic               cmd_take
);

    localparam int QD   = 2;
    localparam int QP_W = $clog2(QD);
    localparam int QC_W = $clog2(QD + 1);

    ise_pkg::cmd_t    q_mem [QD];
    logic [QP_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  cnt_reg, cnt_next;

    ise_pkg::cmd_kind_t kind;
    logic               known;
    logic               enq;
    logic               deq;

    always_comb
    begin
        known = 1'b1;
        kind  = ise_pkg::K_PUSH;
        unique case (op)
            ise_pkg::OP_PUSH: kind = ise_pkg::K_PUSH;
            ise_pkg::OP_DUMP: kind = ise_pkg::K_DUMP;
            ise_pkg::OP_POP:  kind = ise_pkg::K_POP;
            ise_pkg::OP_PEEK: kind = ise_pkg::K_PEEK;
            ise_pkg::OP_SWAP: kind = ise_pkg::K_SWAP;
            default:          known = 1'b0;
        endcase
    end

    assign full      = (cnt_reg == QC_W'(QD));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign enq       = push && !full && known;
    assign deq       = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg].kind  <= kind;
            q_mem[wr_ptr_reg].value <= value;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ise_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_back
// stack memory, entry count and sequencer that carries out queued commands
// and loads results into the output register
// ----------------------------------------------------------------------------
module ise_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ise_pkg::cmd_t      cmd,
    input  wire logic               cmd_valid,
    output logic                    cmd_take,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      data,
    output logic                    data_valid,
    output logic [2:0]              status,
    output logic                    last,
    output ise_pkg::back_stat_t     stat
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SWAP1 = 4'b0100,
        S_SWAP2 = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] mem [ise_pkg::DEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    logic [ise_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ise_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [ise_pkg::REM_W-1:0]  rem_reg, rem_next;

    logic                       out_valid_reg;
    logic signed [31:0]         out_data_reg;
    logic                       out_dv_reg;
    logic [2:0]                 out_status_reg;
    logic                       out_last_reg;

    logic                       load;
    logic signed [31:0]         ld_data;
    logic                       ld_dv;
    logic [2:0]                 ld_status;
    logic                       ld_last;

    logic                       rd_en;
    logic [ise_pkg::ADDR_W-1:0] rd_a_addr;
    logic [ise_pkg::ADDR_W-1:0] rd_b_addr;
    logic                       wr_en;
    logic [ise_pkg::ADDR_W-1:0] wr_addr;
    logic [31:0]                wr_data;

    logic                       out_free;
    logic [ise_pkg::CNT_W-1:0]  cnt_m1;
    logic [ise_pkg::CNT_W-1:0]  cnt_m2;
    logic [ise_pkg::ADDR_W-1:0] top_addr;
    logic [ise_pkg::ADDR_W-1:0] below_addr;
    logic                       is_empty;
    logic                       is_full;
    logic                       is_short;
    logic [ise_pkg::REM_W-1:0]  dump_cnt;

    assign out_free   = !out_valid_reg || pop;
    assign cnt_m1     = count_reg - 1'b1;
    assign cnt_m2     = count_reg - 2'd2;
    assign top_addr   = cnt_m1[ise_pkg::ADDR_W-1:0];
    assign below_addr = cnt_m2[ise_pkg::ADDR_W-1:0];
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == ise_pkg::CNT_W'(ise_pkg::DEPTH));
    assign is_short   = (count_reg < ise_pkg::CNT_W'(2));
    assign dump_cnt   = (int'(count_reg) > ise_pkg::MAX_RESULTS)
                      ? ise_pkg::REM_W'(ise_pkg::MAX_RESULTS)
                      : ise_pkg::REM_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        cmd_take   = 1'b0;
        load       = 1'b0;
        ld_data    = '0;
        ld_dv      = 1'b0;
        ld_status  = ise_pkg::ST_OK;
        ld_last    = 1'b1;
        rd_en      = 1'b0;
        rd_a_addr  = top_addr;
        rd_b_addr  = below_addr;
        wr_en      = 1'b0;
        wr_addr    = top_addr;
        wr_data    = cmd.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        ise_pkg::K_PUSH:
                        begin
                            if (out_free)
                            begin
                                cmd_take = 1'b1;
                                load     = 1'b1;
                                if (is_full)
                                begin
                                    ld_status = ise_pkg::ST_OVERFLOW;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[ise_pkg::ADDR_W-1:0];
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        ise_pkg::K_POP:
                        begin
                            if (out_free)
                            begin
                                cmd_take = 1'b1;
                                load     = 1'b1;
                                if (is_empty)
                                begin
                                    ld_status = ise_pkg::ST_POP_EMPTY;
                                end
                                else
                                begin
                                    count_next = cnt_m1;
                                end
                            end
                        end
                        ise_pkg::K_PEEK:
                        begin
                            if (is_empty)
                            begin
                                if (out_free)
                                begin
                                    cmd_take  = 1'b1;
                                    load      = 1'b1;
                                    ld_status = ise_pkg::ST_PEEK_EMPTY;
                                end
                            end
                            else
                            begin
                                // a peek is a dump of one entry
                                cmd_take   = 1'b1;
                                rd_en      = 1'b1;
                                idx_next   = top_addr;
                                rem_next   = ise_pkg::REM_W'(1);
                                state_next = S_READ;
                            end
                        end
                        ise_pkg::K_DUMP:
                        begin
                            cmd_take = 1'b1;
                            if (!is_empty)
                            begin
                                rd_en      = 1'b1;
                                idx_next   = top_addr;
                                rem_next   = dump_cnt;
                                state_next = S_READ;
                            end
                        end
                        ise_pkg::K_SWAP:
                        begin
                            if (is_short)
                            begin
                                if (out_free)
                                begin
                                    cmd_take  = 1'b1;
                                    load      = 1'b1;
                                    ld_status = ise_pkg::ST_SWAP_SHORT;
                                end
                            end
                            else
                            begin
                                cmd_take   = 1'b1;
                                rd_en      = 1'b1;
                                state_next = S_SWAP1;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // read data waits in rd_a_reg until the output register frees
                if (out_free)
                begin
                    load    = 1'b1;
                    ld_data = rd_a_reg;
                    ld_dv   = 1'b1;
                    ld_last = (rem_reg == ise_pkg::REM_W'(1));
                    if (rem_reg == ise_pkg::REM_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_a_addr = idx_reg - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                        rem_next  = rem_reg - 1'b1;
                    end
                end
            end
            S_SWAP1:
            begin
                wr_en      = 1'b1;
                wr_addr    = top_addr;
                wr_data    = rd_b_reg;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = below_addr;
                    wr_data    = rd_a_reg;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        if (load)
        begin
            out_data_reg   <= ld_data;
            out_dv_reg     <= ld_dv;
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign empty      = !out_valid_reg;
    assign data       = out_data_reg;
    assign data_valid = out_dv_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;
    assign stat.idle  = (state_reg == S_IDLE);
    assign stat.count = count_reg;

endmodule

`default_nettype wire
